### rtl/rlm_pkg.sv
// ----------------------------------------------------------------------------
// rlm_pkg: shared constants for the RMS level meter
// Fixed-point widths, scale factors and reset values used by the meter core.
// ----------------------------------------------------------------------------
`default_nettype none

package rlm_pkg;

    // Default window length in samples
    localparam int unsigned DEF_MAX_WINDOW = 65536;

    // PCM sample, result and floor register widths
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned LEVEL_W  = 16;
    localparam int unsigned FLOOR_W  = 8;

    // log2 mantissa is Q1.31 held in 32 bits; 16 fraction bits are produced
    localparam int unsigned MANT_W        = 32;
    localparam int unsigned LOG_FRAC_BITS = 16;
    localparam int unsigned ITER_W        = $clog2(LOG_FRAC_BITS);

    // Shared multiplier operand width
    localparam int unsigned MUL_W = 32;

    // 2560*log10(2) in Q16 and its width
    localparam logic [25:0] DB_PER_LOG2_Q16 = 26'd50504453;
    localparam int unsigned DB_W            = 26;

    // Full scale squared is 2^30: offset in log2 Q16
    localparam int unsigned FS_LOG2 = 30;

    // Reset value of the floor register, whole dB
    localparam logic signed [FLOOR_W-1:0] FLOOR_RESET = -8'sd60;

    typedef logic signed [LEVEL_W-1:0] level_t;

endpackage : rlm_pkg

`default_nettype wire

### rtl/rms_level_meter_db_top.sv
// ----------------------------------------------------------------------------
// rms_level_meter_db_top: RMS level meter in dB full scale
// Accumulates squared PCM samples and a sample count; a tick beat returns the
// window level in 1/256 dB steps, clamped to the floor, and clears the window.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload                        Handshake
//  s_       in         tdata[15:0] sample,            s_tvalid / s_tready
//                      tuser[0] req_type (1 = tick)
//  m_       out        tdata[15:0] level_db           m_tvalid / m_tready
//  cfg_     in         data[7:0] floor_db             cfg_valid / cfg_ready
//
//  A sample is accepted, then squared and added on the shared 32x32
//  multiplier; a sample at a full window is accepted and dropped. A tick
//  runs two log2 evaluations, each a normalising shift (8 or 1 bits a
//  cycle) and 16 squaring steps on the same multiplier, then a difference,
//  a scaling multiply and the output load. An empty or silent window goes
//  straight to the output load. Reset is synchronous, active low, and needs
//  no clearing pass. A result waiting on m_ does not stop samples; a tick
//  waits only at its last step.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_level_meter_db_top #(
    parameter int unsigned MAX_WINDOW = rlm_pkg::DEF_MAX_WINDOW
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input beats
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [rlm_pkg::SAMPLE_W-1:0]     s_tdata,   // [15:0] sample
    input  wire logic                             s_tuser,   // [0] req_type
    // result beats
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [rlm_pkg::LEVEL_W-1:0]           m_tdata,   // [15:0] level_db
    // floor register
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [rlm_pkg::FLOOR_W-1:0]      cfg_data   // [7:0] floor_db
);
    import rlm_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int unsigned SUM_W = CNT_W + FS_LOG2;
    localparam int unsigned NW    = (SUM_W > MANT_W) ? SUM_W : MANT_W;
    localparam int unsigned E_W   = $clog2(NW);
    localparam int unsigned LOG_W = E_W + LOG_FRAC_BITS;
    localparam int unsigned D_W   = LOG_W + 2;
    localparam int unsigned ND_W  = LOG_W + 1;
    localparam int unsigned R_W   = ND_W + DB_W - MUL_W + 1;
    localparam int unsigned LV_W  = R_W + 1;

    localparam logic [CNT_W-1:0] WIN_MAX = CNT_W'(MAX_WINDOW);
    localparam logic signed [D_W-1:0] FS_OFFSET = D_W'(FS_LOG2 << LOG_FRAC_BITS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ACC   = 3'd1;
    localparam logic [2:0] ST_NORM  = 3'd2;
    localparam logic [2:0] ST_LOGSQ = 3'd3;
    localparam logic [2:0] ST_DIFF  = 3'd4;
    localparam logic [2:0] ST_SCALE = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]                 state_reg, state_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [FLOOR_W-1:0]         floor_reg;
    logic [SAMPLE_W-1:0]        mag_reg, mag_next;
    logic [NW-1:0]              norm_reg, norm_next;
    logic [E_W-1:0]             shift_reg, shift_next;
    logic [MANT_W-1:0]          mant_reg, mant_next;
    logic [E_W-1:0]             exp_reg, exp_next;
    logic [LOG_FRAC_BITS-1:0]   frac_reg, frac_next;
    logic [ITER_W-1:0]          iter_reg, iter_next;
    logic                       phase_reg, phase_next;
    logic [LOG_W-1:0]           logsum_reg, logsum_next;
    logic [ND_W-1:0]            negd_reg, negd_next;
    level_t                     level_reg, level_next;
    level_t                     mdata_reg, mdata_next;
    logic                       mvalid_reg, mvalid_next;

    logic [MUL_W-1:0]           mul_a, mul_b;
    logic [2*MUL_W-1:0]         prod;
    logic [MANT_W:0]            sq;
    logic [LOG_FRAC_BITS-1:0]   frac_step;
    logic [LOG_W-1:0]           log_val;
    logic signed [D_W-1:0]      diff;
    logic [2*MUL_W-1:0]         rounded;
    logic signed [LV_W-1:0]     lvl;
    level_t                     floor_q;
    logic signed [LV_W-1:0]     floor_ext;
    logic                       s_beat, out_load;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_beat    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = mdata_reg;
    assign out_load  = (state_reg == ST_OUT) && (!mvalid_reg || m_tready);

    assign floor_q   = {floor_reg, 8'h00};
    assign floor_ext = LV_W'(floor_q);

    // Shared multiplier operand select
    always_comb begin
        unique case (state_reg)
            ST_ACC: begin
                mul_a = MUL_W'(mag_reg);
                mul_b = MUL_W'(mag_reg);
            end
            ST_LOGSQ: begin
                mul_a = mant_reg;
                mul_b = mant_reg;
            end
            ST_SCALE: begin
                mul_a = MUL_W'(negd_reg);
                mul_b = MUL_W'(DB_PER_LOG2_Q16);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod      = mul_a * mul_b;
    assign sq        = prod[MANT_W+31:31];
    assign frac_step = {frac_reg[LOG_FRAC_BITS-2:0], sq[MANT_W]};
    assign log_val   = {exp_reg, frac_step};
    assign diff      = $signed(D_W'(logsum_reg)) - $signed(D_W'({exp_reg, frac_reg}))
                     - FS_OFFSET;
    assign rounded   = prod + 64'h0000_0000_8000_0000;
    assign lvl       = -$signed({1'b0, rounded[MUL_W +: R_W]});

    always_comb begin
        state_next  = state_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        mag_next    = mag_reg;
        norm_next   = norm_reg;
        shift_next  = shift_reg;
        mant_next   = mant_reg;
        exp_next    = exp_reg;
        frac_next   = frac_reg;
        iter_next   = iter_reg;
        phase_next  = phase_reg;
        logsum_next = logsum_reg;
        negd_next   = negd_reg;
        level_next  = level_reg;
        mdata_next  = mdata_reg;
        mvalid_next = mvalid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    if (s_tuser) begin
                        if (cnt_reg == '0 || sum_reg == '0) begin
                            level_next = floor_q;
                            state_next = ST_OUT;
                        end else begin
                            norm_next  = NW'(sum_reg);
                            shift_next = '0;
                            phase_next = 1'b0;
                            state_next = ST_NORM;
                        end
                    end else if (cnt_reg < WIN_MAX) begin
                        mag_next   = s_tdata[SAMPLE_W-1] ? SAMPLE_W'(~s_tdata + 1'b1)
                                                         : s_tdata;
                        state_next = ST_ACC;
                    end
                end
            end
            ST_ACC: begin
                sum_next   = sum_reg + SUM_W'(prod);
                cnt_next   = cnt_reg + 1'b1;
                state_next = ST_IDLE;
            end
            ST_NORM: begin
                // coarse then fine shift until the top bit is set
                priority if (norm_reg[NW-1]) begin
                    mant_next  = norm_reg[NW-1 -: MANT_W];
                    exp_next   = E_W'(NW - 1) - shift_reg;
                    frac_next  = '0;
                    iter_next  = '0;
                    state_next = ST_LOGSQ;
                end else if (norm_reg[NW-1 -: 8] == 8'h00) begin
                    norm_next  = norm_reg << 8;
                    shift_next = shift_reg + E_W'(8);
                end else begin
                    norm_next  = norm_reg << 1;
                    shift_next = shift_reg + 1'b1;
                end
            end
            ST_LOGSQ: begin
                mant_next = sq[MANT_W] ? sq[MANT_W:1] : sq[MANT_W-1:0];
                frac_next = frac_step;
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(LOG_FRAC_BITS - 1)) begin
                    if (!phase_reg) begin
                        logsum_next = log_val;
                        phase_next  = 1'b1;
                        norm_next   = NW'(cnt_reg);
                        shift_next  = '0;
                        state_next  = ST_NORM;
                    end else begin
                        state_next  = ST_DIFF;
                    end
                end
            end
            ST_DIFF: begin
                // log value of the count sits in exp_reg/frac_reg here
                if (!diff[D_W-1]) begin
                    level_next = floor_q[LEVEL_W-1] ? level_t'(0) : floor_q;
                    state_next = ST_OUT;
                end else begin
                    negd_next  = ND_W'(-diff);
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                level_next = (lvl < floor_ext) ? floor_q : lvl[LEVEL_W-1:0];
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    mvalid_next = 1'b1;
                    mdata_next  = level_reg;
                    sum_next    = '0;
                    cnt_next    = '0;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            sum_reg    <= '0;
            cnt_reg    <= '0;
            floor_reg  <= FLOOR_RESET;
            mvalid_reg <= 1'b0;
            phase_reg  <= 1'b0;
            iter_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            sum_reg    <= sum_next;
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
            phase_reg  <= phase_next;
            iter_reg   <= iter_next;
            if (cfg_valid && cfg_ready) begin
                floor_reg <= cfg_data;
            end
        end
    end

    // Datapath registers are always loaded before they are read
    always_ff @(posedge aclk) begin
        mag_reg    <= mag_next;
        norm_reg   <= norm_next;
        shift_reg  <= shift_next;
        mant_reg   <= mant_next;
        exp_reg    <= exp_next;
        frac_reg   <= frac_next;
        logsum_reg <= logsum_next;
        negd_reg   <= negd_next;
        level_reg  <= level_next;
        mdata_reg  <= mdata_next;
    end

    // Window never grows past its limit
    a_cnt_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= WIN_MAX)
        else $error("sample count above window limit");

    // An empty window holds no energy
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (sum_reg == '0))
        else $error("square sum non-zero in empty window");

    // Delivering a level clears the window
    a_tick_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (cnt_reg == '0 && sum_reg == '0 && m_tvalid))
        else $error("window not cleared after level beat");

endmodule : rms_level_meter_db_top

`default_nettype wire
